@@ src/tofhm_pkg.sv @@
package tofhm_pkg;

  localparam int SENSORS_DEF = 6;
  localparam int ONLINE_W    = 6;

  localparam logic [13:0] OOR_MARK    = 14'd9999;
  localparam logic [15:0] RAW_LIMIT   = 16'd8190;
  localparam logic [7:0]  ERR_LIMIT   = 8'd8;
  localparam logic [7:0]  ERR_MAX     = 8'd255;
  localparam logic [5:0]  EXPECT_MASK = 6'h3f;

  localparam logic [5:0]  ONLINE_RST       = 6'h3f;
  localparam logic [12:0] MAX_RANGE_RST    = 13'd2000;
  localparam logic [15:0] STALE_RST        = 16'd1500;
  localparam logic [15:0] OOR_STALE_RST    = 16'd3000;
  localparam logic [13:0] GOOD_MAX_RST     = 14'd1200;
  localparam logic [2:0]  MIN_BAD_RST      = 3'd3;
  localparam logic [2:0]  MIN_GOOD_RST     = 3'd2;
  localparam logic [15:0] SCAN_INTERVAL_RST = 16'd1000;

  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_CHECK = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_DATA  = 2'd1,
    ST_FETCH    = 2'd2,
    ST_CHAN_ERR = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_ONLINE_MASK   = 3'd0,
    REG_MAX_RANGE     = 3'd1,
    REG_STALE         = 3'd2,
    REG_OOR_STALE     = 3'd3,
    REG_GOOD_MAX      = 3'd4,
    REG_MIN_BAD       = 3'd5,
    REG_MIN_GOOD      = 3'd6,
    REG_SCAN_INTERVAL = 3'd7
  } cfg_reg_t;

  // Outcome of the shared age compare: age = now - stamp, modulo 2^32.
  typedef struct packed {
    logic gt;
    logic ge;
  } age_res_t;

endpackage

@@ src/tofhm_age_unit.sv @@
module tofhm_age_unit import tofhm_pkg::*; (
  input  logic [31:0] now,
  input  logic [31:0] stamp,
  input  logic [15:0] limit,
  output age_res_t    res
);

  logic [31:0] age;
  logic        lt;
  logic        eq;

  // The subtraction wraps, so a timer that crossed zero still ages correctly.
  assign age    = now - stamp;
  assign lt     = age < {16'd0, limit};
  assign eq     = age == {16'd0, limit};
  assign res.gt = !lt && !eq;
  assign res.ge = !lt;

endmodule

@@ src/tof_sensor_array_health_monitor_core.sv @@
// Health monitor for an array of distance sensors. Each input transfer carries
// one operation in s_tuser: a poll outcome for one sensor, a round health
// check, a clear of the recovery flag or no operation; each gives exactly one
// result transfer. A poll or a clear passes the EXEC and DONE states; a health
// check walks SWEEP once per sensor entry, then SCAN and DONE, since a single
// 32-bit age subtract-and-compare unit is visited once per sensor entry and
// once more for the bus scan interval. Only one item is in work at a time;
// the result register lets the next item be accepted while a result waits.
module tof_sensor_array_health_monitor_core import tofhm_pkg::*; #(
  parameter int SENSORS = SENSORS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: sensor[2:0], fetch_status[4:3], distance_mm[20:5],
  //          now_ms[52:21], scan_mask[59:53], zero fill
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,
  // s_tuser: op[1:0]
  input  logic [1:0]  s_tuser,
  // m_tdata: stored_distance[13:0], recovery[14], error_count[22:15],
  //          bad_count[25:23], good_count[28:26], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = $clog2(SENSORS);
  localparam int CNT_W = $clog2(SENSORS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SWEEP = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [5:0]  online_mask;
  logic [12:0] max_range_mm;
  logic [15:0] stale_ms;
  logic [15:0] oor_stale_ms;
  logic [13:0] good_max_mm;
  logic [2:0]  min_bad;
  logic [2:0]  min_good;
  logic [15:0] scan_interval_ms;

  // Latched item.
  op_t         op_q;
  logic [2:0]  sensor_q;
  status_t     status_q;
  logic [15:0] mm_q;
  logic [31:0] now_q;
  logic [6:0]  mask_q;

  // Per-sensor state.
  logic [13:0] distance_store [SENSORS];
  logic [31:0] oor_start_time [SENSORS];
  logic        oor_active     [SENSORS];
  logic [31:0] last_good_time [SENSORS];
  logic [7:0]  sensor_errors  [SENSORS];

  logic        recovery_flag;
  logic [31:0] last_scan_time;
  logic [2:0]  bad_cnt;
  logic [2:0]  good_cnt;

  logic [IDX_W-1:0] cnt;
  logic [CNT_W-1:0] bad_acc;
  logic [CNT_W-1:0] good_acc;

  logic [IDX_W-1:0] sidx;
  logic             svalid;
  logic             online;
  logic [7:0]       online_ext;
  logic [IDX_W-1:0] rd_idx;
  logic [13:0]      rd_dist;
  logic [7:0]       err_cur;
  logic [7:0]       err_bump;
  logic [7:0]       err_new;
  logic [31:0]      unit_stamp;
  logic [15:0]      unit_limit;
  age_res_t         age;
  logic             semantic_hit;
  logic             scan_fault;
  logic             out_load;

  assign sidx       = IDX_W'(32'(sensor_q));
  assign svalid     = 32'(sensor_q) < SENSORS;
  assign online_ext = {2'b00, online_mask};
  assign online     = (sensor_q < 3'(ONLINE_W)) && online_ext[sensor_q];

  // One read address into the sensor arrays: the sweep walks it, else the item's sensor.
  assign rd_idx   = (state == S_SWEEP) ? cnt : sidx;
  assign rd_dist  = distance_store[rd_idx];
  assign err_cur  = sensor_errors[rd_idx];
  assign err_bump = (err_cur != ERR_MAX) ? err_cur + 8'd1 : err_cur;
  assign err_new  = (status_q == ST_FETCH) ? err_bump : err_cur;

  always_comb begin
    case (state)
      S_EXEC: begin
        unit_stamp = last_good_time[rd_idx];
        unit_limit = stale_ms;
      end
      S_SWEEP: begin
        unit_stamp = oor_start_time[rd_idx];
        unit_limit = oor_stale_ms;
      end
      default: begin
        unit_stamp = last_scan_time;
        unit_limit = scan_interval_ms;
      end
    endcase
  end

  tofhm_age_unit u_age (
    .now   (now_q),
    .stamp (unit_stamp),
    .limit (unit_limit),
    .res   (age)
  );

  assign semantic_hit = (32'(bad_acc) >= 32'(min_bad)) && (32'(good_acc) >= 32'(min_good));
  assign scan_fault   = (mask_q[5:0] != EXPECT_MASK) || mask_q[6];
  assign out_load     = (state == S_DONE) && (!m_tvalid || m_tready);
  assign s_tready     = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_ONLINE_MASK:   online_mask      <= cfg_data[5:0];
        REG_MAX_RANGE:     max_range_mm     <= cfg_data[12:0];
        REG_STALE:         stale_ms         <= cfg_data;
        REG_OOR_STALE:     oor_stale_ms     <= cfg_data;
        REG_GOOD_MAX:      good_max_mm      <= cfg_data[13:0];
        REG_MIN_BAD:       min_bad          <= cfg_data[2:0];
        REG_MIN_GOOD:      min_good         <= cfg_data[2:0];
        REG_SCAN_INTERVAL: scan_interval_ms <= cfg_data;
        default: ;
      endcase
    end
    if (rst) begin
      online_mask      <= ONLINE_RST;
      max_range_mm     <= MAX_RANGE_RST;
      stale_ms         <= STALE_RST;
      oor_stale_ms     <= OOR_STALE_RST;
      good_max_mm      <= GOOD_MAX_RST;
      min_bad          <= MIN_BAD_RST;
      min_good         <= MIN_GOOD_RST;
      scan_interval_ms <= SCAN_INTERVAL_RST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_tvalid       <= 1'b0;
      recovery_flag  <= 1'b0;
      last_scan_time <= 32'd0;
      bad_cnt        <= 3'd0;
      good_cnt       <= 3'd0;
      cnt            <= '0;
      bad_acc        <= '0;
      good_acc       <= '0;
      for (int i = 0; i < SENSORS; i++) begin
        distance_store[i] <= OOR_MARK;
        oor_start_time[i] <= 32'd0;
        oor_active[i]     <= 1'b0;
        last_good_time[i] <= 32'd0;
        sensor_errors[i]  <= 8'd0;
      end
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q     <= op_t'(s_tuser);
            sensor_q <= s_tdata[2:0];
            status_q <= status_t'(s_tdata[4:3]);
            mm_q     <= s_tdata[20:5];
            now_q    <= s_tdata[52:21];
            mask_q   <= s_tdata[59:53];
            cnt      <= '0;
            bad_acc  <= '0;
            good_acc <= '0;
            state    <= (op_t'(s_tuser) == OP_CHECK) ? S_SWEEP : S_EXEC;
          end
        end
        S_EXEC: begin
          if (op_q == OP_CLEAR) begin
            recovery_flag <= 1'b0;
          end else if (op_q == OP_POLL && svalid) begin
            if (!online) begin
              distance_store[sidx] <= OOR_MARK;
              recovery_flag        <= 1'b1;
            end else begin
              case (status_q)
                ST_OK: begin
                  last_good_time[sidx] <= now_q;
                  sensor_errors[sidx]  <= 8'd0;
                  if (mm_q >= RAW_LIMIT || mm_q == 16'd0) begin
                    distance_store[sidx] <= OOR_MARK;
                    if (!oor_active[sidx]) begin
                      oor_active[sidx]     <= 1'b1;
                      oor_start_time[sidx] <= now_q;
                    end
                  end else begin
                    distance_store[sidx] <= (mm_q < {3'd0, max_range_mm}) ?
                                            mm_q[13:0] : {1'b0, max_range_mm};
                    oor_active[sidx]     <= 1'b0;
                  end
                end
                ST_CHAN_ERR: begin
                  sensor_errors[sidx] <= err_bump;
                end
                default: begin
                  sensor_errors[sidx] <= err_new;
                  if (age.gt || err_new >= ERR_LIMIT) begin
                    recovery_flag <= 1'b1;
                  end
                end
              endcase
            end
          end
          state <= S_DONE;
        end
        S_SWEEP: begin
          if (rd_dist == OOR_MARK && oor_active[cnt] && age.gt) begin
            bad_acc <= bad_acc + CNT_W'(1);
          end else if (rd_dist != 14'd0 && rd_dist < good_max_mm) begin
            good_acc <= good_acc + CNT_W'(1);
          end
          if (cnt == IDX_W'(SENSORS - 1)) begin
            state <= S_SCAN;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        S_SCAN: begin
          bad_cnt  <= (32'(bad_acc) > 32'd7) ? 3'd7 : 3'(bad_acc);
          good_cnt <= (32'(good_acc) > 32'd7) ? 3'd7 : 3'(good_acc);
          if (age.ge) begin
            last_scan_time <= now_q;
          end
          if (semantic_hit || (age.ge && scan_fault)) begin
            recovery_flag <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'd0, good_cnt, bad_cnt,
                  svalid ? err_cur : 8'd0,
                  recovery_flag,
                  svalid ? rd_dist : OOR_MARK};
    end
  end

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != S_IDLE))
    else $error("accepted transfer did not start work");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (32'(cnt) < SENSORS))
    else $error("sweep index beyond the sensor array");

  a_recovery_clear_only_by_op: assert property (@(posedge clk) disable iff (rst)
    $fell(recovery_flag) |-> $past(state == S_EXEC && op_q == OP_CLEAR))
    else $error("recovery flag dropped without a clear operation");
`endif

endmodule

@@ verif/tofhm_health_checker.sv @@
module tofhm_health_checker import tofhm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // s_tdata: sensor[2:0], fetch_status[4:3], distance_mm[20:5],
  //          now_ms[52:21], scan_mask[59:53], zero fill
  input  logic [63:0] s_tdata,
  // s_tuser: op[1:0]
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: stored_distance[13:0], recovery[14], error_count[22:15],
  //          bad_count[25:23], good_count[28:26], zero fill
  input  logic [31:0] m_tdata,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          checked
);

  localparam int NS = SENSORS_DEF;

  typedef struct packed {
    logic [13:0] stored;
    logic        rec;
    logic [7:0]  errs;
    logic [2:0]  bad;
    logic [2:0]  good;
  } health_result_t;

  health_result_t expected_health[$];
  health_result_t got_res, want_res;
  int fail_count;
  int result_count;

  // Array state.
  logic [13:0] dist_mem  [NS];
  logic [31:0] oor_since [NS];
  logic        oor_on    [NS];
  logic [31:0] good_at   [NS];
  logic [7:0]  err_cnt   [NS];
  logic        recover;
  logic [31:0] scan_at;
  logic [2:0]  bad_q, good_q;

  // Register copies.
  logic [5:0]  online;
  logic [12:0] max_range;
  logic [15:0] stale_lim, oor_lim, scan_gap;
  logic [13:0] good_max;
  logic [2:0]  bad_need, good_need;

  task automatic reset_model();
    online    = ONLINE_RST;
    max_range = MAX_RANGE_RST;
    stale_lim = STALE_RST;
    oor_lim   = OOR_STALE_RST;
    good_max  = GOOD_MAX_RST;
    bad_need  = MIN_BAD_RST;
    good_need = MIN_GOOD_RST;
    scan_gap  = SCAN_INTERVAL_RST;
    for (int i = 0; i < NS; i++) begin
      dist_mem[i]  = OOR_MARK;
      oor_since[i] = '0;
      oor_on[i]    = 1'b0;
      good_at[i]   = '0;
      err_cnt[i]   = '0;
    end
    recover = 1'b0;
    scan_at = '0;
    bad_q   = '0;
    good_q  = '0;
  endtask

  task automatic bump_errors(input logic [2:0] sn);
    if (err_cnt[sn] != ERR_MAX) err_cnt[sn] = err_cnt[sn] + 8'd1;
  endtask

  task automatic predict_health(input op_t op, input logic [2:0] sn, input status_t st,
                                input logic [15:0] mm, input logic [31:0] now,
                                input logic [6:0] mask, output health_result_t res);
    logic [31:0] age;
    int n_bad;
    int n_good;
    case (op)
      OP_POLL: begin
        if (sn < NS) begin
          if (!online[sn]) begin
            dist_mem[sn] = OOR_MARK;
            recover = 1'b1;
          end else if (st == ST_OK) begin
            good_at[sn] = now;
            err_cnt[sn] = '0;
            if (mm >= RAW_LIMIT || mm == 16'd0) begin
              dist_mem[sn] = OOR_MARK;
              // The out-of-range timer keeps its first start time.
              if (!oor_on[sn]) begin
                oor_on[sn]    = 1'b1;
                oor_since[sn] = now;
              end
            end else begin
              if (mm < {3'd0, max_range}) dist_mem[sn] = mm[13:0];
              else dist_mem[sn] = {1'b0, max_range};
              oor_on[sn] = 1'b0;
            end
          end else if (st == ST_CHAN_ERR) begin
            bump_errors(sn);
          end else begin
            if (st == ST_FETCH) bump_errors(sn);
            age = now - good_at[sn];
            if (age > {16'd0, stale_lim} || err_cnt[sn] >= ERR_LIMIT) recover = 1'b1;
          end
        end
      end
      OP_CHECK: begin
        n_bad  = 0;
        n_good = 0;
        for (int i = 0; i < NS; i++) begin
          age = now - oor_since[i];
          if (dist_mem[i] == OOR_MARK && oor_on[i] && age > {16'd0, oor_lim})
            n_bad++;
          else if (dist_mem[i] != 14'd0 && dist_mem[i] < good_max)
            n_good++;
        end
        if (n_bad >= bad_need && n_good >= good_need) recover = 1'b1;
        if (n_bad > 7) n_bad = 7;
        if (n_good > 7) n_good = 7;
        bad_q  = n_bad[2:0];
        good_q = n_good[2:0];
        age = now - scan_at;
        if (age >= {16'd0, scan_gap}) begin
          scan_at = now;
          if (mask[5:0] != EXPECT_MASK || mask[6]) recover = 1'b1;
        end
      end
      OP_CLEAR: recover = 1'b0;
      default: ;
    endcase
    res.stored = (sn < NS) ? dist_mem[sn] : OOR_MARK;
    res.rec    = recover;
    res.errs   = (sn < NS) ? err_cnt[sn] : 8'd0;
    res.bad    = bad_q;
    res.good   = good_q;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      expected_health.delete();
      outstanding <= 0;
    end else begin
      // Results are checked before the new item is predicted, since no
      // result can belong to an item accepted at the same edge.
      if (m_tvalid && m_tready) begin
        got_res.stored = m_tdata[13:0];
        got_res.rec    = m_tdata[14];
        got_res.errs   = m_tdata[22:15];
        got_res.bad    = m_tdata[25:23];
        got_res.good   = m_tdata[28:26];
        if (expected_health.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Mismatch at %0t: result transfer with nothing pending, data %h",
                     $time, m_tdata);
        end else begin
          want_res = expected_health.pop_front();
          result_count++;
          if (got_res != want_res) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("Mismatch at %0t: expected mm=%0d rec=%0d err=%0d bad=%0d good=%0d",
                       $time, want_res.stored, want_res.rec, want_res.errs, want_res.bad,
                       want_res.good);
              $display("  actual mm=%0d rec=%0d err=%0d bad=%0d good=%0d",
                       got_res.stored, got_res.rec, got_res.errs, got_res.bad,
                       got_res.good);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_health(op_t'(s_tuser), s_tdata[2:0], status_t'(s_tdata[4:3]),
                       s_tdata[20:5], s_tdata[52:21], s_tdata[59:53], want_res);
        expected_health.push_back(want_res);
      end
      if (cfg_wen) begin
        case (cfg_reg_t'(cfg_index))
          REG_ONLINE_MASK:   online    = cfg_data[5:0];
          REG_MAX_RANGE:     max_range = cfg_data[12:0];
          REG_STALE:         stale_lim = cfg_data;
          REG_OOR_STALE:     oor_lim   = cfg_data;
          REG_GOOD_MAX:      good_max  = cfg_data[13:0];
          REG_MIN_BAD:       bad_need  = cfg_data[2:0];
          REG_MIN_GOOD:      good_need = cfg_data[2:0];
          REG_SCAN_INTERVAL: scan_gap  = cfg_data;
          default: ;
        endcase
      end
      outstanding <= expected_health.size();
    end
    mismatches <= fail_count;
    checked    <= result_count;
  end

endmodule

@@ verif/tb_tof_sensor_array_health_monitor_core.sv @@
module tb_tof_sensor_array_health_monitor_core;
  import tofhm_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // s_tdata: sensor[2:0], fetch_status[4:3], distance_mm[20:5],
  //          now_ms[52:21], scan_mask[59:53], zero fill
  logic [63:0] s_tdata;
  // s_tuser: op[1:0]
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // m_tdata: stored_distance[13:0], recovery[14], error_count[22:15],
  //          bad_count[25:23], good_count[28:26], zero fill
  logic [31:0] m_tdata;
  logic        cfg_wen;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int mismatches;
  int outstanding;
  int checked;

  int snd_idle;
  int rcv_idle;
  int items_sent;
  int op_seen [4];
  logic [31:0] clock_ms;

  tof_sensor_array_health_monitor_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tofhm_health_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding), .checked(checked)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      m_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic send_item(input op_t op, input logic [2:0] sn, input status_t st,
                           input logic [15:0] mm, input logic [31:0] now,
                           input logic [6:0] mask);
    while ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tuser  <= op;
    s_tdata  <= {4'd0, mask, now, mm, st, sn};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    op_seen[op]++;
    items_sent++;
  endtask

  // The checker's pending count is registered, so it is read only after the
  // input side has been quiet over a clock edge.
  task automatic wait_drained();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [15:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_settings(input logic [15:0] online, input logic [15:0] max_rng,
                                  input logic [15:0] stale, input logic [15:0] oor,
                                  input logic [15:0] good_max, input logic [15:0] bad_need,
                                  input logic [15:0] good_need, input logic [15:0] scan);
    cfg_write(REG_ONLINE_MASK, online);
    cfg_write(REG_MAX_RANGE, max_rng);
    cfg_write(REG_STALE, stale);
    cfg_write(REG_OOR_STALE, oor);
    cfg_write(REG_GOOD_MAX, good_max);
    cfg_write(REG_MIN_BAD, bad_need);
    cfg_write(REG_MIN_GOOD, good_need);
    cfg_write(REG_SCAN_INTERVAL, scan);
    cfg_wen <= 1'b0;
  endtask

  task automatic program_random(input logic [5:0] online);
    program_settings({10'd0, online}, 16'($urandom_range(500, 3000)),
                     16'($urandom_range(0, 5000)), 16'($urandom_range(0, 6000)),
                     16'($urandom_range(1, 9999)), 16'($urandom_range(0, 6)),
                     16'($urandom_range(0, 6)), 16'($urandom_range(0, 3000)));
  endtask

  task automatic advance_time();
    int r;
    r = $urandom_range(99);
    if (r < 70) clock_ms = clock_ms + $urandom_range(0, 400);
    else if (r < 90) clock_ms = clock_ms + $urandom_range(400, 8000);
    else if (r < 97) clock_ms = clock_ms + $urandom_range(8000, 80000);
    else clock_ms = $urandom;
  endtask

  function automatic status_t pick_status();
    if ($urandom_range(99) < 55) return ST_OK;
    return status_t'($urandom_range(3));
  endfunction

  // Biased toward the clamp, the raw limit and zero.
  function automatic logic [15:0] pick_distance();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom_range(1, 3000));
    if (r < 75) return 16'($urandom_range(3000, 9000));
    if (r < 85) return 16'd0;
    if (r < 92) return 16'($urandom_range(8188, 8191));
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [6:0] pick_mask();
    if ($urandom_range(99) < 80) return 7'h3f;
    return 7'($urandom_range(127));
  endfunction

  // One acquisition round: outcomes for most sensors, then a health check and at times a clear.
  task automatic poll_round();
    advance_time();
    for (int i = 0; i < SENSORS_DEF; i++) begin
      if ($urandom_range(99) < 80) begin
        clock_ms = clock_ms + $urandom_range(0, 30);
        send_item(OP_POLL, i[2:0], pick_status(), pick_distance(), clock_ms, 7'h3f);
      end
    end
    send_item(OP_CHECK, 3'($urandom_range(7)), status_t'($urandom_range(3)),
              16'($urandom_range(65535)), clock_ms, pick_mask());
    if ($urandom_range(99) < 30)
      send_item(OP_CLEAR, 3'($urandom_range(7)), status_t'($urandom_range(3)),
                16'($urandom_range(65535)), clock_ms, 7'($urandom_range(127)));
  endtask

  task automatic noise_item();
    int r;
    op_t op;
    r = $urandom_range(99);
    if (r < 50) op = OP_POLL;
    else if (r < 75) op = OP_CHECK;
    else if (r < 90) op = OP_CLEAR;
    else op = OP_NONE;
    advance_time();
    send_item(op, 3'($urandom_range(7)), status_t'($urandom_range(3)),
              16'($urandom_range(65535)), clock_ms, 7'($urandom_range(127)));
  endtask

  initial begin
    int seg_end;
    int next_drain;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_POLL;
    cfg_wen   <= 1'b0;
    cfg_index <= REG_ONLINE_MASK;
    cfg_data  <= '0;
    snd_idle  = 15;
    rcv_idle  = 65;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset settings.
    send_item(OP_POLL, 3'd0, ST_OK, 16'd0, 32'd100, 7'h3f);
    send_item(OP_POLL, 3'd1, ST_OK, 16'd8190, 32'd100, 7'h3f);
    send_item(OP_POLL, 3'd2, ST_OK, 16'hffff, 32'd100, 7'h3f);
    send_item(OP_POLL, 3'd3, ST_OK, 16'd8189, 32'd100, 7'h3f);
    send_item(OP_POLL, 3'd4, ST_OK, 16'd1, 32'd100, 7'h3f);
    send_item(OP_POLL, 3'd5, ST_OK, 16'd500, 32'd100, 7'h3f);
    send_item(OP_POLL, 3'd0, ST_OK, 16'd0, 32'd200, 7'h3f);
    send_item(OP_CHECK, 3'd0, ST_OK, 16'd0, 32'd3500, 7'h3f);
    send_item(OP_CLEAR, 3'd1, ST_OK, 16'd0, 32'd3500, 7'h00);
    send_item(OP_POLL, 3'd3, ST_NO_DATA, 16'd0, 32'd3500, 7'h3f);
    send_item(OP_CLEAR, 3'd3, ST_OK, 16'd0, 32'd3500, 7'h3f);
    send_item(OP_POLL, 3'd4, ST_FETCH, 16'd0, 32'd3500, 7'h3f);
    send_item(OP_POLL, 3'd5, ST_CHAN_ERR, 16'd0, 32'd3500, 7'h3f);
    send_item(OP_POLL, 3'd6, ST_OK, 16'd700, 32'd3500, 7'h3f);
    send_item(OP_POLL, 3'd7, ST_FETCH, 16'd700, 32'd3500, 7'h3f);
    send_item(OP_NONE, 3'd2, ST_OK, 16'd0, 32'd3500, 7'h7f);
    send_item(OP_CHECK, 3'd2, ST_OK, 16'd0, 32'd3600, 7'h7f);
    send_item(OP_CHECK, 3'd2, ST_OK, 16'd0, 32'd4600, 7'h7f);
    send_item(OP_CLEAR, 3'd7, ST_OK, 16'd0, 32'd4600, 7'h3f);
    send_item(OP_CHECK, 3'd4, ST_OK, 16'd0, 32'd5700, 7'h1f);
    send_item(OP_POLL, 3'd0, ST_OK, 16'd8189, 32'hffff_ff00, 7'h3f);
    send_item(OP_POLL, 3'd0, ST_NO_DATA, 16'd0, 32'h0000_0100, 7'h3f);
    // A sensor that is not online is forced out of range.
    wait_drained();
    cfg_write(REG_ONLINE_MASK, 16'h001e);
    cfg_wen <= 1'b0;
    send_item(OP_POLL, 3'd5, ST_OK, 16'd300, 32'h0000_0200, 7'h3f);
    clock_ms = 32'h0000_0200;

    next_drain = items_sent + 150;
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        snd_idle = 65;
        rcv_idle = 15;
      end
      if (seg == 4) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      wait_drained();
      case (seg)
        0: program_settings(16'($urandom_range(63)), 16'd1, 16'd0, 16'd0, 16'd1, 16'd0,
                            16'd0, 16'd0);
        2: program_settings(16'h003f, 16'd8189, 16'hffff, 16'hffff, 16'd9999, 16'd6, 16'd6,
                            16'hffff);
        3: program_random(6'h00);
        5: program_random(6'h3f);
        default: program_random(6'($urandom_range(63)));
      endcase
      // A failing sensor: its error count runs into saturation.
      if (seg == 5) begin
        for (int k = 0; k < 270; k++) begin
          clock_ms = clock_ms + $urandom_range(0, 50);
          send_item(OP_POLL, 3'd2, (k % 40 == 39) ? ST_NO_DATA : status_t'($urandom_range(2, 3)),
                    16'($urandom_range(65535)), clock_ms, 7'h3f);
        end
      end
      seg_end = items_sent + ((seg == 3) ? 90 : 180);
      while (items_sent < seg_end) begin
        if ($urandom_range(99) < 80) poll_round();
        else noise_item();
        if (items_sent >= next_drain) begin
          wait_drained();
          next_drain = items_sent + $urandom_range(100, 200);
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Run covered %0d poll outcomes, %0d health checks, %0d clears, %0d unused ops,",
             op_seen[OP_POLL], op_seen[OP_CHECK], op_seen[OP_CLEAR], op_seen[OP_NONE]);
    $display("over six register settings; %0d results compared, %0d mismatches.",
             checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ tof_sensor_array_health_monitor_core.f @@
src/tofhm_pkg.sv
src/tofhm_age_unit.sv
src/tof_sensor_array_health_monitor_core.sv
verif/tofhm_health_checker.sv
verif/tb_tof_sensor_array_health_monitor_core.sv
